// ----- rtl/core/fcgi_nv_pkg.sv -----
// ----------------------------------------------------------------------------
// FastCGI name-value parser package
// Shared types and constants for the name-value pair parser.
// ----------------------------------------------------------------------------
`default_nettype none

package fcgi_nv_pkg;

	// Default width of an assembled key or value length
	localparam int LENGTH_BITS_DEF = 31;

	// Length encoding: top bit selects the four-byte form
	localparam logic [7:0] LEN_LONG_FLAG = 8'h80;
	localparam logic [7:0] LEN_LOW_MASK  = 8'h7f;

	// Input command
	localparam logic CMD_DATA = 1'b0;
	localparam logic CMD_EOS  = 1'b1;

	// Parser phase
	typedef enum logic [1:0] {
		PH_KLEN = 2'd0,
		PH_VLEN = 2'd1,
		PH_KEY  = 2'd2,
		PH_VAL  = 2'd3
	} phase_t;

	// Result kind
	typedef enum logic [2:0] {
		K_KEY   = 3'd0,
		K_VAL   = 3'd1,
		K_EMPTY = 3'd2,
		K_DONE  = 3'd3,
		K_TRUNC = 3'd4
	} kind_t;

endpackage

`default_nettype wire

// ----- rtl/core/fastcgi_name_value_parser_core.sv -----
// ----------------------------------------------------------------------------
// FastCGI name-value parser core
// Splits FastCGI parameter-record body bytes into tagged key and value bytes.
// ----------------------------------------------------------------------------
// The result of an input transfer is registered and reaches the master side in the next cycle.
// Throughput: one byte per cycle while the result side keeps up; the state
// update and the result register load happen in the same cycle. A result held
// in the output register by a stalled master side holds off the next input.
// Reset: arst_n clears the phase, length counters and output valid at once.
`default_nettype none

module fastcgi_name_value_parser_core #(
	parameter int LENGTH_BITS = fcgi_nv_pkg::LENGTH_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Input stream
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  wire logic        s_axis_tuser,   // [0] command
	// Result stream
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [15:0]      m_axis_tdata,   // [7:0] out_byte, [9:8] error_phase, rest 0
	output logic [3:0]       m_axis_tuser,   // [2:0] kind, [3] key_last
	output logic             m_axis_tlast    // pair_last
);

	import fcgi_nv_pkg::*;

	localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};
	localparam logic [LENGTH_BITS-1:0] LEN_ONE = LENGTH_BITS'(1);

	// State registers
	phase_t                 phase_q, phase_d;
	logic [1:0]             cnt_q, cnt_d;
	logic [LENGTH_BITS-1:0] key_len_q, key_len_d;
	logic [LENGTH_BITS-1:0] val_len_q, val_len_d;
	logic [LENGTH_BITS-1:0] rem_q, rem_d;

	// Output register
	logic       out_valid_q;
	kind_t      out_kind_q;
	logic [7:0] out_byte_q;
	logic       out_klast_q;
	logic       out_plast_q;
	logic [1:0] out_ephase_q;

	// Result of the current byte
	logic       res_valid;
	kind_t      res_kind;
	logic [7:0] res_byte;
	logic       res_klast;
	logic       res_plast;
	logic [1:0] res_ephase;

	logic       in_xfer;
	logic       cmd;
	logic [7:0] din;

	// Length assembly
	logic [LENGTH_BITS-1:0] len_src;
	logic [LENGTH_BITS+7:0] len_wide;
	logic [LENGTH_BITS-1:0] len_new;
	logic                   len_done;
	logic [1:0]             len_cnt;
	logic                   rem_last;

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign cmd           = s_axis_tuser;
	assign din           = s_axis_tdata;
	assign rem_last      = (rem_q <= LEN_ONE);

	// One length byte: short form, or one of four bytes with saturation
	always_comb begin
		len_src  = (phase_q == PH_KLEN) ? key_len_q : val_len_q;
		len_wide = {len_src, din};
		len_new  = len_src;
		len_done = 1'b0;
		len_cnt  = cnt_q;
		if (cnt_q == 2'd0) begin
			if ((din & LEN_LONG_FLAG) == 8'h00) begin
				len_new  = LENGTH_BITS'(din);
				len_done = 1'b1;
			end else begin
				len_new = LENGTH_BITS'(din & LEN_LOW_MASK);
				len_cnt = 2'd1;
			end
		end else begin
			len_new = (|len_wide[LENGTH_BITS+7:LENGTH_BITS]) ? LEN_MAX
				: len_wide[LENGTH_BITS-1:0];
			if (cnt_q == 2'd3) begin
				len_cnt  = 2'd0;
				len_done = 1'b1;
			end else begin
				len_cnt = cnt_q + 2'd1;
			end
		end
	end

	// Next state
	always_comb begin
		phase_d   = phase_q;
		cnt_d     = cnt_q;
		key_len_d = key_len_q;
		val_len_d = val_len_q;
		rem_d     = rem_q;
		if (cmd == CMD_EOS) begin
			phase_d   = PH_KLEN;
			cnt_d     = 2'd0;
			key_len_d = '0;
			val_len_d = '0;
			rem_d     = '0;
		end else begin
			unique case (phase_q)
				PH_KLEN: begin
					cnt_d     = len_cnt;
					key_len_d = len_new;
					if (len_done) phase_d = PH_VLEN;
				end
				PH_VLEN: begin
					cnt_d     = len_cnt;
					val_len_d = len_new;
					if (len_done) begin
						if (key_len_q != '0) begin
							phase_d = PH_KEY;
							rem_d   = key_len_q;
						end else if (len_new != '0) begin
							phase_d = PH_VAL;
							rem_d   = len_new;
						end else begin
							phase_d   = PH_KLEN;
							key_len_d = '0;
							val_len_d = '0;
							rem_d     = '0;
						end
					end
				end
				PH_KEY: begin
					if (!rem_last) begin
						rem_d = rem_q - LEN_ONE;
					end else if (val_len_q == '0) begin
						phase_d   = PH_KLEN;
						key_len_d = '0;
						rem_d     = '0;
					end else begin
						phase_d = PH_VAL;
						rem_d   = val_len_q;
					end
				end
				PH_VAL: begin
					if (!rem_last) begin
						rem_d = rem_q - LEN_ONE;
					end else begin
						phase_d   = PH_KLEN;
						key_len_d = '0;
						val_len_d = '0;
						rem_d     = '0;
					end
				end
				default: phase_d = PH_KLEN;
			endcase
		end
	end

	// Result of the current byte
	always_comb begin
		res_valid  = 1'b0;
		res_kind   = K_KEY;
		res_byte   = 8'h00;
		res_klast  = 1'b0;
		res_plast  = 1'b0;
		res_ephase = 2'd0;
		if (cmd == CMD_EOS) begin
			res_valid = 1'b1;
			if (phase_q == PH_KLEN && cnt_q == 2'd0) begin
				res_kind = K_DONE;
			end else begin
				res_kind   = K_TRUNC;
				res_ephase = phase_q;
			end
		end else begin
			unique case (phase_q)
				PH_KLEN: res_valid = 1'b0;
				PH_VLEN: begin
					if (len_done && key_len_q == '0 && len_new == '0) begin
						res_valid = 1'b1;
						res_kind  = K_EMPTY;
						res_plast = 1'b1;
					end
				end
				PH_KEY: begin
					res_valid = 1'b1;
					res_kind  = K_KEY;
					res_byte  = din;
					res_klast = rem_last;
					res_plast = rem_last && (val_len_q == '0);
				end
				PH_VAL: begin
					res_valid = 1'b1;
					res_kind  = K_VAL;
					res_byte  = din;
					res_plast = rem_last;
				end
				default: res_valid = 1'b0;
			endcase
		end
	end

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_KLEN;
			cnt_q     <= 2'd0;
			key_len_q <= '0;
			val_len_q <= '0;
			rem_q     <= '0;
		end else if (in_xfer) begin
			phase_q   <= phase_d;
			cnt_q     <= cnt_d;
			key_len_q <= key_len_d;
			val_len_q <= val_len_d;
			rem_q     <= rem_d;
		end
	end

	// Output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_xfer) begin
			out_valid_q <= res_valid;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (in_xfer && res_valid) begin
			out_kind_q   <= res_kind;
			out_byte_q   <= res_byte;
			out_klast_q  <= res_klast;
			out_plast_q  <= res_plast;
			out_ephase_q <= res_ephase;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'b0, out_ephase_q, out_byte_q};
	assign m_axis_tuser  = {out_klast_q, out_kind_q};
	assign m_axis_tlast  = out_plast_q;

endmodule

`default_nettype wire
